// ===== design/hasum_pkg.sv =====
// Shared constants, types and functions for the top-h absolute sum bound check.
package hasum_pkg;

	localparam int TOP_COUNT = 40;
	localparam int COEF_W = 16;
	localparam int MAG_W = 15;
	localparam int SUM_W = 21;
	localparam int BOUND_W = 24;
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	typedef struct packed {
		logic ins;
		logic clr;
	} cell_ctl_t;

	// Absolute value of a coefficient; the most negative code saturates.
	function automatic logic [MAG_W-1:0] magnitude_of(input logic [COEF_W-1:0] c);
		logic [COEF_W-1:0] n;
		n = c[COEF_W-1] ? (~c + COEF_W'(1)) : c;
		return n[COEF_W-1] ? MAG_MAX : n[MAG_W-1:0];
	endfunction

endpackage

// ===== design/hasum_cell.sv =====
// One cell of the sorted insertion chain, holding one kept magnitude.
module hasum_cell
	import hasum_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [MAG_W-1:0] mag,
	input  logic             prev_gt,
	input  logic [MAG_W-1:0] prev_val,
	output logic             gt,
	output logic [MAG_W-1:0] val
);

	logic [MAG_W-1:0] val_q;

	assign gt  = mag > val_q;
	assign val = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ctl.clr) begin
			val_q <= '0;
		end else if (ctl.ins && gt) begin
			val_q <= prev_gt ? prev_val : mag;
		end
	end

endmodule

// ===== design/top_h_abs_sum_bound_check.sv =====
// Top level: keeps the largest coefficient magnitudes and checks their sum.
// The result word is registered and appears in the cycle after the last coefficient is accepted.
// Throughput: one coefficient per cycle while in_stall is low, set by the compare in every cell
// and the running-sum adder that tracks the kept values.
// The input stalls only while a finished result waits and the output is stalled.
// Reset clears all cells, the running sum, the result register and the bound.
module top_h_abs_sum_bound_check
	import hasum_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COEF_W-1:0]  coefficient,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               reject,
	output logic [SUM_W-1:0]   top_sum,
	input  logic               cfg_wr_en,
	input  logic [BOUND_W-1:0] cfg_wr_data
);

	logic [BOUND_W-1:0] sum_bound_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   sum_next;
	logic               out_valid_q;
	logic               reject_q;
	logic [SUM_W-1:0]   top_sum_q;
	logic               accept;
	logic               accept_last;
	logic [MAG_W-1:0]   mag;
	cell_ctl_t          ctl;
	logic [TOP_COUNT-1:0] gt_w;
	logic [MAG_W-1:0]   val_w [TOP_COUNT];
	logic               sorted_ok;

	assign in_stall    = out_valid_q && out_stall;
	assign accept      = in_valid && !in_stall;
	assign accept_last = accept && last;
	assign mag         = magnitude_of(coefficient);
	assign ctl.ins     = accept;
	assign ctl.clr     = accept_last;

	for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_head
			hasum_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.mag      (mag),
				.prev_gt  (1'b0),
				.prev_val ('0),
				.gt       (gt_w[i]),
				.val      (val_w[i])
			);
		end else begin : g_body
			hasum_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.mag      (mag),
				.prev_gt  (gt_w[i-1]),
				.prev_val (val_w[i-1]),
				.gt       (gt_w[i]),
				.val      (val_w[i])
			);
		end
	end

	// The tail value drops out of the store whenever the new magnitude is kept.
	always_comb begin
		if (gt_w[TOP_COUNT-1]) begin
			sum_next = sum_q + SUM_W'(mag) - SUM_W'(val_w[TOP_COUNT-1]);
		end else begin
			sum_next = sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_bound_q <= '0;
		end else if (cfg_wr_en) begin
			sum_bound_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept_last) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_sum_q <= '0;
			reject_q  <= 1'b0;
		end else if (accept_last) begin
			top_sum_q <= sum_next;
			reject_q  <= BOUND_W'(sum_next) > sum_bound_q;
		end
	end

	assign out_valid = out_valid_q;
	assign reject    = reject_q;
	assign top_sum   = top_sum_q;

	always_comb begin
		sorted_ok = 1'b1;
		for (int i = 1; i < TOP_COUNT; i++) begin
			if (val_w[i] > val_w[i-1]) begin
				sorted_ok = 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n) sorted_ok)
		else $error("Kept magnitudes are not in descending order.");

	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept_last |=> (sum_q == '0) && (val_w[0] == '0))
		else $error("Store was not cleared after the last coefficient.");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept_last |=> out_valid)
		else $error("No result word after the last coefficient.");
`endif

endmodule

// ===== tb/sv/top_h_abs_sum_bound_check_tb.sv =====
// Testbench for the top-h absolute sum bound check: directed table, then random polynomials.
`timescale 1ns / 100ps

module top_h_abs_sum_bound_check_tb;
	import hasum_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 180;
	localparam int PHASE_POLYS = 4;
	localparam int PHASE_COUNT = 6;
	localparam int ROW_COUNT = 16;

	typedef struct packed {
		logic             reject;
		logic [SUM_W-1:0] top_sum;
	} sum_result_t;

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic              lst;
		logic              typed;
		logic              rej;
		logic [SUM_W-1:0]  sum;
	} directed_row_t;

	typedef enum int {MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_TIES} coef_mix_t;

	localparam directed_row_t DIRECTED_ROWS [ROW_COUNT] = '{
		'{16'h0000, 1'b1, 1'b1, 1'b0, 21'd0},
		'{16'h7FFF, 1'b1, 1'b1, 1'b1, 21'd32767},
		'{16'h8001, 1'b1, 1'b1, 1'b1, 21'd32767},
		'{16'h8000, 1'b1, 1'b1, 1'b1, 21'd32767},
		'{16'h0001, 1'b1, 1'b1, 1'b1, 21'd1},
		'{16'hFFFF, 1'b1, 1'b1, 1'b1, 21'd1},
		'{16'hFFFB, 1'b0, 1'b0, 1'b0, 21'd0},
		'{16'h0007, 1'b0, 1'b0, 1'b0, 21'd0},
		'{16'hFFFB, 1'b0, 1'b0, 1'b0, 21'd0},
		'{16'h012C, 1'b1, 1'b0, 1'b0, 21'd0},
		'{16'h8000, 1'b0, 1'b0, 1'b0, 21'd0},
		'{16'h7FFF, 1'b0, 1'b0, 1'b0, 21'd0},
		'{16'h4000, 1'b0, 1'b0, 1'b0, 21'd0},
		'{16'hC000, 1'b1, 1'b0, 1'b0, 21'd0},
		'{16'h0000, 1'b0, 1'b0, 1'b0, 21'd0},
		'{16'h0000, 1'b1, 1'b1, 1'b0, 21'd0}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [COEF_W-1:0]  coefficient;
	logic               last;
	logic               out_valid;
	logic               out_stall;
	logic               reject;
	logic [SUM_W-1:0]   top_sum;
	logic               cfg_wr_en;
	logic [BOUND_W-1:0] cfg_wr_data;

	logic [MAG_W-1:0]   kept_mags [TOP_COUNT];
	logic [BOUND_W-1:0] bound_model;
	sum_result_t        pending_sums [$];
	sum_result_t        oldest_sum;
	int                 send_idle;
	int                 recv_idle;
	int                 errors;
	int                 cycle_count = 0;

	top_h_abs_sum_bound_check uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coefficient (coefficient),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.reject      (reject),
		.top_sum     (top_sum),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected result word: reject %0d, top_sum %0d", reject, top_sum);
				errors++;
			end else begin
				oldest_sum = pending_sums.pop_front();
				if (reject !== oldest_sum.reject) begin
					$error("reject: expected %0d, actual %0d", oldest_sum.reject, reject);
					errors++;
				end
				if (top_sum !== oldest_sum.top_sum) begin
					$error("top_sum: expected %0d, actual %0d", oldest_sum.top_sum, top_sum);
					errors++;
				end
			end
		end
	end

	function automatic logic [MAG_W-1:0] abs_clamped(input logic [COEF_W-1:0] c);
		int v;
		v = $signed(c);
		if (v < 0)
			v = -v;
		if (v > (1 << MAG_W) - 1)
			v = (1 << MAG_W) - 1;
		return v[MAG_W-1:0];
	endfunction

	task automatic absorb_coefficient(input logic [COEF_W-1:0] c, input logic lst,
			output logic done, output sum_result_t res);
		logic [MAG_W-1:0] m;
		int pos;
		int total;
		m = abs_clamped(c);
		pos = TOP_COUNT;
		for (int i = 0; i < TOP_COUNT && pos == TOP_COUNT; i++)
			if (m > kept_mags[i])
				pos = i;
		for (int i = TOP_COUNT - 1; i > pos; i--)
			kept_mags[i] = kept_mags[i-1];
		if (pos < TOP_COUNT)
			kept_mags[pos] = m;
		done = lst;
		res = '0;
		if (lst) begin
			total = 0;
			foreach (kept_mags[i]) begin
				total += kept_mags[i];
				kept_mags[i] = '0;
			end
			res.top_sum = total[SUM_W-1:0];
			res.reject = (total > bound_model);
		end
	endtask

	task automatic send_word(input logic [COEF_W-1:0] c, input logic lst, input logic typed,
			input sum_result_t typed_res);
		logic done;
		sum_result_t res;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		coefficient <= c;
		last <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		absorb_coefficient(c, lst, done, res);
		if (done)
			pending_sums.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	task automatic go_quiet();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_sums.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_bound(input logic [BOUND_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		bound_model = v;
	endtask

	task automatic random_polynomial(output int count);
		int len;
		int r;
		coef_mix_t mix;
		logic [COEF_W-1:0] c;
		logic [COEF_W-1:0] tie;
		sum_result_t none;
		r = $urandom_range(99);
		if (r < 10)
			len = $urandom_range(1, 3);
		else if (r < 70)
			len = $urandom_range(4, 45);
		else
			len = $urandom_range(46, 90);
		mix = coef_mix_t'($urandom_range(3));
		tie = COEF_W'($urandom_range(0, 65535));
		none = '0;
		for (int k = 0; k < len; k++) begin
			case (mix)
				MIX_FULL: c = COEF_W'($urandom_range(0, 65535));
				MIX_SMALL: c = COEF_W'($urandom_range(0, 128)) - COEF_W'(64);
				MIX_EXTREME: begin
					case ($urandom_range(5))
						0: c = 16'h7FFF;
						1: c = 16'h8001;
						2: c = 16'h8000;
						3: c = 16'h0000;
						4: c = 16'h0001;
						default: c = 16'hFFFF;
					endcase
				end
				default: c = ($urandom_range(3) == 0) ? COEF_W'($urandom_range(0, 65535)) : tie;
			endcase
			send_word(c, k == len - 1, 1'b0, none);
		end
		count = len;
	endtask

	initial begin
		int phase_items;
		int phase_polys;
		int n;
		logic [BOUND_W-1:0] bounds [PHASE_COUNT];
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		coefficient = '0;
		last = 1'b0;
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		send_idle = 0;
		recv_idle = 0;
		errors = 0;
		bound_model = '0;
		foreach (kept_mags[i])
			kept_mags[i] = '0;
		bounds[0] = 24'hFFFFFF;
		bounds[1] = 24'd1310680;
		bounds[2] = 24'd1310679;
		bounds[3] = BOUND_W'($urandom_range(0, 1 << 20));
		bounds[4] = '0;
		bounds[5] = BOUND_W'($urandom_range(0, 4000));
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle = 17;
		recv_idle = 48;
		foreach (DIRECTED_ROWS[i])
			send_word(DIRECTED_ROWS[i].coef, DIRECTED_ROWS[i].lst, DIRECTED_ROWS[i].typed,
				'{DIRECTED_ROWS[i].rej, DIRECTED_ROWS[i].sum});
		for (int p = 0; p < PHASE_COUNT; p++) begin
			go_quiet();
			write_bound(bounds[p]);
			send_idle = (p < 2) ? 17 : (p < 4) ? 48 : 0;
			recv_idle = (p < 2) ? 48 : (p < 4) ? 17 : 0;
			phase_items = 0;
			phase_polys = 0;
			while (phase_items < PHASE_ITEMS || phase_polys < PHASE_POLYS) begin
				if (phase_polys == 2)
					go_quiet();
				random_polynomial(n);
				phase_items += n;
				phase_polys++;
			end
		end
		go_quiet();
		if (errors == 0 && pending_sums.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== top_h_abs_sum_bound_check.f =====
design/hasum_pkg.sv
design/hasum_cell.sv
design/top_h_abs_sum_bound_check.sv
tb/sv/top_h_abs_sum_bound_check_tb.sv
